// ----- hdl/rgb_led_animation_engine_top_defines.svh -----
// Assertion macros for the LED animation engine.
`ifndef RGB_LED_ANIMATION_ENGINE_TOP_DEFINES_SVH
`define RGB_LED_ANIMATION_ENGINE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define RGBLED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RGBLED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);
`else
`define RGBLED_ASSERT(lbl, prop, msg)
`define RGBLED_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/rgbled_pkg.sv -----
package rgbled_pkg;

  localparam int unsigned LED_IDX_W = 5;
  localparam int unsigned HUE_W     = 9;
  localparam int unsigned VAL_W     = 8;
  localparam int unsigned LAYER_W   = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 8;

  localparam logic [HUE_W-1:0] HUE_WRAP = 9'd360;
  localparam logic [VAL_W-1:0] SAT_FULL = 8'd255;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_SPRD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_DIV = 3'd4;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_RAINBOW = 2'd1,
    MODE_FADE    = 2'd2
  } mode_e;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [VAL_W-1:0] bright;
  } led_entry_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [VAL_W-1:0] sat;
    logic [VAL_W-1:0] bright;
  } hsv_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       override;
    logic       digit_lit;
    logic       pick_hit;
  } pix_ctrl_t;

  // White digit shown on a layer change; bit i is LED i.
  function automatic logic [19:0] digit_row(logic [LAYER_W-1:0] layer);
    logic [19:0] row;
    case (layer)
      5'd0:    row = 20'h69996;
      5'd1:    row = 20'h22262;
      5'd2:    row = 20'hF4296;
      default: row = '0;
    endcase
    return row;
  endfunction

endpackage

// ----- hdl/rgbled_in_if.sv -----
interface rgbled_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [rgbled_pkg::LAYER_W-1:0]         active_layer;
  logic [rgbled_pkg::LED_IDX_W-1:0]       random_led;
  logic [rgbled_pkg::HUE_W-1:0]           random_hue;

  modport source (output valid, active_layer, random_led, random_hue, input ready);
  modport sink   (input valid, active_layer, random_led, random_hue, output ready);
endinterface

// ----- hdl/rgbled_out_if.sv -----
interface rgbled_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [rgbled_pkg::LED_IDX_W-1:0]       led_index;
  logic [rgbled_pkg::HUE_W-1:0]           hue;
  logic [rgbled_pkg::VAL_W-1:0]           saturation;
  logic [rgbled_pkg::VAL_W-1:0]           brightness;
  logic                                   last_led;

  modport source (output valid, led_index, hue, saturation, brightness, last_led,
                  input ready);
  modport sink   (input valid, led_index, hue, saturation, brightness, last_led,
                  output ready);
endinterface

// ----- hdl/rgbled_pixel.sv -----
module rgbled_pixel (
  input  rgbled_pkg::pix_ctrl_t             ctrl_i,
  input  rgbled_pkg::led_entry_t            entry_i,
  input  logic [rgbled_pkg::HUE_W-1:0]      rb_hue_i,
  input  logic [rgbled_pkg::HUE_W-1:0]      rhue_i,
  input  logic [rgbled_pkg::VAL_W-1:0]      max_value_i,
  input  logic [rgbled_pkg::VAL_W-1:0]      fade_step_i,
  output rgbled_pkg::led_entry_t            entry_o,
  output rgbled_pkg::hsv_t                  color_o
);
  import rgbled_pkg::*;

  led_entry_t lit;

  // light the picked LED if dark, then fade with floor at zero
  always_comb begin
    lit = entry_i;
    if (ctrl_i.pick_hit && entry_i.bright == '0) begin
      lit.hue    = rhue_i;
      lit.bright = max_value_i;
    end
    entry_o = lit;
    entry_o.bright = (lit.bright > fade_step_i) ? lit.bright - fade_step_i : '0;
  end

  always_comb begin
    color_o = '0;
    if (ctrl_i.override) begin
      color_o.bright = ctrl_i.digit_lit ? max_value_i : '0;
    end else begin
      case (ctrl_i.mode)
        MODE_RAINBOW: begin
          color_o.hue    = rb_hue_i;
          color_o.sat    = SAT_FULL;
          color_o.bright = max_value_i;
        end
        MODE_FADE: begin
          color_o.hue    = entry_o.hue;
          color_o.sat    = SAT_FULL;
          color_o.bright = entry_o.bright;
        end
        default: color_o = '0;
      endcase
    end
  end

endmodule

// ----- hdl/rgb_led_animation_engine_top.sv -----
// LED animation engine.
// in_i carries one scan tick per transaction (active layer, random LED pick,
// random hue); out_o returns LED_COUNT HSV transactions per tick, LED 0 first,
// last_led set on the final one. cfg_we_i/cfg_idx_i/cfg_data_i write the mode,
// max value, fade step, hue spread and speed divider; write only while idle.
// Per-LED fade state (hue, brightness) lives in a small synchronous RAM with a
// registered read; each LED is read, updated and written back in turn.
// Throughput: when out_o never stalls, the engine takes the tick, reads LED 0
// from the RAM, then moves one LED per cycle through the read/modify/write
// pipeline; each LED passes the RAM read stage and then the output register.
// in_i.ready is high only while no LED of the previous tick is still pending
// in the read stage; the final result may still sit in the output register.
// A stall on out_o freezes the read stage and the RAM read; nothing is lost.
// Reset clears the sequencer and output-valid registers, animation counters and
// per-LED valid bits, so every LED reads as dark with hue 0; no clearing pass is needed.
`include "rgb_led_animation_engine_top_defines.svh"

module rgb_led_animation_engine_top #(
  parameter int unsigned LED_COUNT = 20
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  rgbled_in_if.sink                            in_i,
  rgbled_out_if.source                         out_o,
  input  logic                                 cfg_we_i,
  input  logic [rgbled_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rgbled_pkg::CFG_DAT_W-1:0]     cfg_data_i
);
  import rgbled_pkg::*;

  localparam int unsigned AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned CW = $clog2(LED_COUNT + 1);

  typedef enum logic {ST_IDLE, ST_RUN} state_e;

  // configuration
  logic [1:0]       mode_q;
  logic [VAL_W-1:0] max_value_q, fade_step_q, speed_div_q;
  logic [4:0]       hue_spread_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_OFF;
      max_value_q  <= 8'd100;
      fade_step_q  <= 8'd5;
      hue_spread_q <= 5'd5;
      speed_div_q  <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:      mode_q       <= cfg_data_i[1:0];
        CFG_MAX_VALUE: max_value_q  <= cfg_data_i;
        CFG_FADE_STEP: fade_step_q  <= cfg_data_i;
        CFG_HUE_SPRD:  hue_spread_q <= cfg_data_i[4:0];
        CFG_SPEED_DIV: speed_div_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer and tick state
  state_e               state_q;
  logic [CW-1:0]        rd_idx_q;
  logic                 s1_vld_q, s1_ent_vld_q;
  logic [AW-1:0]        s1_idx_q;
  logic [HUE_W-1:0]     phase_q, phase_d;
  logic [HUE_W-1:0]     presc_q, presc_d;
  logic [LAYER_W-1:0]   shown_q, layer_q;
  logic [LED_IDX_W-1:0] pick_q;
  logic [HUE_W-1:0]     rhue_q;
  logic                 override_q;
  logic [HUE_W-1:0]     rb_hue_q;
  logic [HUE_W:0]       rb_sum;
  logic [HUE_W-1:0]     rb_next;
  logic [19:0]          digit_bits;

  // output register
  logic                 out_vld_q;
  hsv_t                 out_col_q;
  logic [LED_IDX_W-1:0] out_idx_q;
  logic                 out_last_q;

  // per-LED RAM
  led_entry_t           led_mem_q [LED_COUNT];
  led_entry_t           mem_rdata_q;
  logic [LED_COUNT-1:0] ent_vld_q;

  logic                 in_acc, out_free, consume, rd_en, mem_we;
  logic [AW-1:0]        rd_addr;
  logic [LED_IDX_W-1:0] s1_led;
  logic                 s1_last;
  led_entry_t           cur_ent, wr_ent;
  hsv_t                 pix_col;
  pix_ctrl_t            pix_ctrl;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;
  assign consume    = s1_vld_q && out_free;
  assign rd_en      = (state_q == ST_RUN) && (rd_idx_q < CW'(LED_COUNT))
                      && (!s1_vld_q || consume);
  assign rd_addr    = rd_idx_q[AW-1:0];
  assign mem_we     = consume && (mode_q == MODE_FADE);
  assign s1_led     = LED_IDX_W'(s1_idx_q);
  assign s1_last    = (s1_idx_q == AW'(LED_COUNT - 1));
  assign cur_ent    = s1_ent_vld_q ? mem_rdata_q : '0;

  // rainbow prescaler step for the tick being taken
  always_comb begin
    phase_d = phase_q;
    presc_d = presc_q;
    if (presc_q >= HUE_W'(speed_div_q)) begin
      presc_d = '0;
      phase_d = phase_q + 1'b1;
    end
    presc_d = presc_d + 1'b1;
    if (phase_d >= HUE_WRAP) phase_d = '0;
  end

  // hue of the next LED: one wrap at most since spread < 32
  assign rb_sum  = {1'b0, rb_hue_q} + (HUE_W + 1)'(hue_spread_q);
  assign rb_next = (rb_sum >= {1'b0, HUE_WRAP}) ? HUE_W'(rb_sum - {1'b0, HUE_WRAP})
                                               : rb_sum[HUE_W-1:0];

  assign digit_bits = digit_row(layer_q);

  always_comb begin
    pix_ctrl.mode      = mode_q;
    pix_ctrl.override  = override_q;
    pix_ctrl.digit_lit = digit_bits[s1_led];
    pix_ctrl.pick_hit  = (pick_q == s1_led);
  end

  rgbled_pixel u_pixel (
    .ctrl_i      (pix_ctrl),
    .entry_i     (cur_ent),
    .rb_hue_i    (rb_hue_q),
    .rhue_i      (rhue_q),
    .max_value_i (max_value_q),
    .fade_step_i (fade_step_q),
    .entry_o     (wr_ent),
    .color_o     (pix_col)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_idx_q <= '0;
      s1_vld_q <= 1'b0;
      phase_q  <= '0;
      presc_q  <= '0;
      shown_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q  <= ST_RUN;
            rd_idx_q <= '0;
            shown_q  <= in_i.active_layer;
            if (mode_q == MODE_RAINBOW) begin
              phase_q <= phase_d;
              presc_q <= presc_d;
            end
          end
        end
        ST_RUN: begin
          if (rd_en) begin
            rd_idx_q <= rd_idx_q + 1'b1;
            s1_vld_q <= 1'b1;
          end else if (consume) begin
            s1_vld_q <= 1'b0;
          end
          if (consume && s1_last) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // tick payload and per-LED stage data
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      layer_q    <= in_i.active_layer;
      pick_q     <= in_i.random_led;
      rhue_q     <= (in_i.random_hue >= HUE_WRAP) ? in_i.random_hue - HUE_WRAP
                                                  : in_i.random_hue;
      override_q <= (in_i.active_layer != shown_q);
      rb_hue_q   <= (mode_q == MODE_RAINBOW) ? phase_d : phase_q;
    end else if (consume) begin
      rb_hue_q   <= rb_next;
    end
    if (rd_en) begin
      s1_idx_q     <= rd_addr;
      s1_ent_vld_q <= ent_vld_q[rd_addr];
    end
  end

  // RAM: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) led_mem_q[s1_idx_q] <= wr_ent;
    if (rd_en)  mem_rdata_q <= led_mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
    end else if (mem_we) begin
      ent_vld_q[s1_idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (consume) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume) begin
      out_col_q  <= pix_col;
      out_idx_q  <= s1_led;
      out_last_q <= s1_last;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.led_index  = out_idx_q;
  assign out_o.hue        = out_col_q.hue;
  assign out_o.saturation = out_col_q.sat;
  assign out_o.brightness = out_col_q.bright;
  assign out_o.last_led   = out_last_q;

  `RGBLED_ASSERT(a_last_index, (out_vld_q && out_last_q) |-> (out_idx_q == LED_IDX_W'(LED_COUNT - 1)), "last flag on wrong LED")
  `RGBLED_ASSERT_NXT(a_stage_hold, (s1_vld_q && out_vld_q && !out_o.ready), s1_vld_q, "read stage dropped while stalled")
  `RGBLED_ASSERT(a_no_rw_clash, (mem_we && rd_en) |-> (s1_idx_q != rd_addr), "RAM read and write hit the same LED")

endmodule
